// ===== hw/rtl/bbrq_pkg.sv =====
package bbrq_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam logic [SIZE_W-1:0] BUDGET_RESET = 32'd1048576;

    // operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              last;
    } t_release;

endpackage

// ===== hw/rtl/bbrq_item_if.sv =====
interface bbrq_item_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [bbrq_pkg::ADDR_W-1:0]    block_addr;
    logic [bbrq_pkg::SIZE_W-1:0]    block_size;

    modport source (output valid, output operation, output block_addr, output block_size,
                    input ready);
    modport sink   (input valid, input operation, input block_addr, input block_size,
                    output ready);
endinterface

// ===== hw/rtl/bbrq_release_if.sv =====
interface bbrq_release_if;
    logic                           valid;
    logic                           ready;
    logic [bbrq_pkg::ADDR_W-1:0]    released_addr;
    logic [bbrq_pkg::SIZE_W-1:0]    released_size;
    logic                           is_last;

    modport source (output valid, output released_addr, output released_size, output is_last,
                    input ready);
    modport sink   (input valid, input released_addr, input released_size, input is_last,
                    output ready);
endinterface

// ===== hw/rtl/bbrq_cfg_if.sv =====
interface bbrq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bbrq_pkg::SIZE_W-1:0]    byte_budget;

    modport source (output valid, output byte_budget, input ready);
    modport sink   (input valid, input byte_budget, output ready);
endinterface

// ===== hw/rtl/bbrq_ram.sv =====
module bbrq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bbrq_out_reg.sv =====
module bbrq_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bbrq_pkg::t_release  i_data,
    output logic                o_free,
    bbrq_release_if.source      o_rel
);
    import bbrq_pkg::*;

    logic     r_valid;
    t_release r_data;

    // slot is free when empty or being drained this cycle
    assign o_free = !r_valid || o_rel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rel.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_rel.valid         = r_valid;
    assign o_rel.released_addr = r_data.addr;
    assign o_rel.released_size = r_data.size;
    assign o_rel.is_last       = r_data.last;

endmodule

// ===== hw/rtl/byte_budget_release_quarantine.sv =====
// Delayed-release quarantine for freed blocks. Each push (operation 0) offers a
// block of block_size bytes at block_addr; each flush (operation 1) hands back
// every held block, oldest first. Held blocks sit in a ring of QUARANTINE_DEPTH
// entries in one single-port-read, single-port-write RAM, bounded both by that
// entry count and by the byte_budget register. A block larger than the budget
// comes straight back as one release. Otherwise the oldest entries are released
// until a slot is free and the held bytes plus the new size fit, and the block
// is then stored. The final release caused by an item carries is_last. The block
// takes one item at a time, with one RAM read per eviction, and its releases wait
// while the result side is stalled. Budget writes are always accepted and must
// be made while no item is in progress.
module byte_budget_release_quarantine #(
    parameter int QUARANTINE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bbrq_cfg_if.sink        i_cfg,
    bbrq_item_if.sink       i_item,
    bbrq_release_if.source  o_rel
);
    import bbrq_pkg::*;

    localparam int IDX_W = (QUARANTINE_DEPTH > 1) ? $clog2(QUARANTINE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUARANTINE_DEPTH + 1);
    localparam int EXC_W = SIZE_W + 2;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUARANTINE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUARANTINE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUARANTINE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EVICT,
        S_APPEND
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_op;
    logic [ADDR_W-1:0]        r_addr;
    logic [SIZE_W-1:0]        r_size;
    logic [IDX_W-1:0]         r_oldest, n_oldest;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [SIZE_W-1:0]        r_bytes, n_bytes;
    // held bytes + new size - budget; positive means the new block does not fit yet
    logic signed [EXC_W-1:0]  r_excess, n_excess;
    logic [SIZE_W-1:0]        r_budget;

    t_entry                   w_head;
    t_entry                   w_wdata;
    t_release                 w_rel;
    logic                     w_free;
    logic                     w_load;
    logic                     w_we;
    logic                     w_accept;
    logic                     w_oversize;
    logic                     w_need_evict;
    logic                     w_more;
    logic                     w_pop;
    logic [IDX_W-1:0]         w_oldest_inc;
    logic [IDX_W:0]           w_tail_sum;
    logic [IDX_W-1:0]         w_tail;
    logic signed [EXC_W-1:0]  w_head_size;

    // ---------------------------------------------------------------------
    // Configuration: single register, always ready
    // ---------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (i_cfg.valid) begin
            r_budget <= i_cfg.byte_budget;
        end
    end

    // ---------------------------------------------------------------------
    // Ring pointers
    // ---------------------------------------------------------------------
    assign w_oldest_inc = (r_oldest == LAST_IDX) ? '0 : r_oldest + 1'b1;
    // tail = (oldest + count) mod depth; the sum stays below twice the depth
    assign w_tail_sum   = (IDX_W + 1)'(r_oldest) + (IDX_W + 1)'(r_count);
    assign w_tail       = (w_tail_sum >= DEPTH_EXT) ? IDX_W'(w_tail_sum - DEPTH_EXT)
                                                    : IDX_W'(w_tail_sum);

    // ---------------------------------------------------------------------
    // Decisions
    // ---------------------------------------------------------------------
    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_oversize   = (r_size > r_budget);
    assign w_need_evict = (r_count != '0) &&
                          ((r_count == FULL_CNT) || (r_excess > $signed(EXC_W'(0))));
    assign w_head_size  = $signed(EXC_W'(w_head.size));
    // another eviction follows this one
    assign w_more       = (r_count != CNT_W'(1)) &&
                          ((r_op == OP_FLUSH) || (r_excess > w_head_size));
    assign w_pop        = (r_state == S_EVICT) && w_free;

    // ---------------------------------------------------------------------
    // Result register load
    // ---------------------------------------------------------------------
    always_comb begin
        w_load = 1'b0;
        w_rel  = '{addr: w_head.addr, size: w_head.size, last: !w_more};
        case (r_state)
            S_EVAL: begin
                if ((r_op == OP_PUSH) && w_oversize && w_free) begin
                    w_load = 1'b1;
                    w_rel  = '{addr: r_addr, size: r_size, last: 1'b1};
                end
            end
            S_EVICT: begin
                w_load = w_free;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Append into the ring
    // ---------------------------------------------------------------------
    assign w_we = (r_state == S_APPEND) ||
                  ((r_state == S_EVAL) && (r_op == OP_PUSH) && !w_oversize && !w_need_evict);
    assign w_wdata = '{addr: r_addr, size: r_size};

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_oldest = r_oldest;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_excess = r_excess;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_EVAL;
                    n_excess = $signed(EXC_W'(r_bytes) + EXC_W'(i_item.block_size)
                                       - EXC_W'(r_budget));
                end
            end
            S_EVAL: begin
                if (r_op == OP_FLUSH) begin
                    n_state = (r_count == '0) ? S_IDLE : S_EVICT;
                end else if (w_oversize) begin
                    if (w_free) begin
                        n_state = S_IDLE;
                    end
                end else if (w_need_evict) begin
                    n_state = S_EVICT;
                end else begin
                    n_state = S_IDLE;
                    n_count = r_count + 1'b1;
                    n_bytes = (r_count == '0) ? r_size : r_bytes + r_size;
                end
            end
            S_EVICT: begin
                if (w_pop) begin
                    n_oldest = w_oldest_inc;
                    n_count  = r_count - 1'b1;
                    n_bytes  = r_bytes - w_head.size;
                    n_excess = r_excess - w_head_size;
                    if (!w_more) begin
                        n_state = (r_op == OP_FLUSH) ? S_IDLE : S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                n_state = S_IDLE;
                n_count = r_count + 1'b1;
                n_bytes = (r_count == '0) ? r_size : r_bytes + r_size;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_excess <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_excess <= n_excess;
        end
    end

    // hold the accepted item for the whole sequence
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_item.operation;
            r_addr <= i_item.block_addr;
            r_size <= i_item.block_size;
        end
    end

    // ---------------------------------------------------------------------
    // Ring store: read address runs one ahead on a pop so the next head is
    // ready in the following cycle
    // ---------------------------------------------------------------------
    bbrq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUARANTINE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tail),
        .i_wdata (w_wdata),
        .i_raddr (n_oldest),
        .o_rdata (w_head)
    );

    bbrq_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_rel),
        .o_free  (w_free),
        .o_rel   (o_rel)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("held count beyond ring depth");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && (r_count == '0) |-> (r_bytes == '0))
        else $error("empty ring still reports held bytes");

    a_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && (r_op == OP_FLUSH) && !w_more |=> (r_count == '0))
        else $error("flush ended with entries left");

    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> (r_count != '0))
        else $error("eviction from an empty ring");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated");

endmodule

// ===== tb/sv/byte_budget_release_quarantine_test.sv =====
`timescale 1ns / 100ps

module byte_budget_release_quarantine_test;
    import bbrq_pkg::*;

    localparam int RING_DEPTH      = 16;
    localparam int CYCLE_LIMIT     = 400000;
    // the slowest item is a push that evicts a full ring;
    // an item that evicts nothing may still be finishing once the last release is out
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_ITEMS     = 36;
    localparam int PRESSURE_ITEMS  = 40;

    // one row of the directed script: a push, a flush or a budget write
    typedef enum int {STEP_PUSH, STEP_FLUSH, STEP_BUDGET} t_step_kind;

    // typed_count < 0: take the releases from the quarantine predictor;
    // otherwise the row carries its own expectation (none, or one final release)
    typedef struct {
        t_step_kind        kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        int                typed_count;
        t_release          typed;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    bbrq_cfg_if     cfg_bus ();
    bbrq_item_if    item_bus ();
    bbrq_release_if rel_bus ();

    byte_budget_release_quarantine #(
        .QUARANTINE_DEPTH (RING_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_item  (item_bus),
        .o_rel   (rel_bus)
    );

    // ------------------------------------------------------------------
    // Quarantine predictor: a private copy of the ring, its byte count
    // and the budget register, advanced on every accepted item.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]               ring_addr [RING_DEPTH];
    logic [SIZE_W-1:0]               ring_size [RING_DEPTH];
    logic [$clog2(RING_DEPTH)-1:0]   ring_head  = '0;
    logic [$clog2(RING_DEPTH):0]     ring_count = '0;
    logic [SIZE_W-1:0]               ring_bytes = '0;
    logic [SIZE_W-1:0]               budget_now = BUDGET_RESET;

    t_release fresh_releases [$];   // releases caused by the item just accepted
    t_release pending_releases [$]; // releases still owed by the block, oldest first

    t_script_row directed_rows [$];

    // expectation that travels with the item on offer; updated with the payload
    int       row_typed_count = -1;
    t_release row_typed       = '0;

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_count = 0;
    int hold_ack_count = 0;
    int hold_left      = 0;

    // Hand the oldest held block back as a non-final release.
    function automatic void hand_back_oldest();
        t_release r;
        r.addr = ring_addr[ring_head];
        r.size = ring_size[ring_head];
        r.last = 1'b0;
        fresh_releases.push_back(r);
        ring_bytes = ring_bytes - ring_size[ring_head];
        ring_head  = (ring_head == RING_DEPTH - 1) ? '0 : ring_head + 1'b1;
        ring_count = ring_count - 1'b1;
    endfunction

    // Advance the quarantine by one item and collect the releases it causes.
    function automatic void quarantine_step(input logic op, input logic [ADDR_W-1:0] addr,
                                            input logic [SIZE_W-1:0] size);
        t_release r;
        int       slot;
        fresh_releases.delete();
        if (op == OP_FLUSH) begin
            while (ring_count != 0)
                hand_back_oldest();
        end else if (size > budget_now) begin
            // oversized block: straight back out, ring untouched
            r.addr = addr;
            r.size = size;
            r.last = 1'b0;
            fresh_releases.push_back(r);
        end else begin
            // evict until a slot is free and the bytes fit; the sum must not wrap
            while (ring_count != 0 &&
                   (ring_count >= RING_DEPTH ||
                    {1'b0, ring_bytes} + {1'b0, size} > {1'b0, budget_now}))
                hand_back_oldest();
            if (ring_count == 0)
                ring_bytes = '0;
            slot = (ring_head + ring_count) % RING_DEPTH;
            ring_addr[slot] = addr;
            ring_size[slot] = size;
            ring_count = ring_count + 1'b1;
            ring_bytes = ring_bytes + size;
        end
        // mark the final release of this item
        if (fresh_releases.size() != 0) begin
            r = fresh_releases.pop_back();
            r.last = 1'b1;
            fresh_releases.push_back(r);
        end
    endfunction

    function automatic t_release final_release(input logic [ADDR_W-1:0] addr,
                                               input logic [SIZE_W-1:0] size);
        t_release r;
        r.addr = addr;
        r.size = size;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input t_step_kind kind, input logic [ADDR_W-1:0] addr,
                                    input logic [SIZE_W-1:0] size, input int typed_count,
                                    input t_release typed);
        t_script_row row;
        row.kind        = kind;
        row.addr        = addr;
        row.size        = size;
        row.typed_count = typed_count;
        row.typed       = typed;
        directed_rows.push_back(row);
    endfunction

    // Block sizes shaped around the current budget so that evictions are common.
    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] budget);
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return $urandom_range(budget >> 2);
        if (roll < 50)
            return $urandom_range(budget);
        if (roll < 60)
            return '0;
        if (roll < 70)
            return budget;
        if (roll < 82 && budget != '1)
            return $urandom_range(32'hFFFF_FFFF, budget + 1);
        return $urandom;
    endfunction

    task automatic report_failure(input string what, input t_release want, input t_release got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected addr=%h size=%h last=%b, got addr=%h size=%h last=%b",
                     $time, what, want.addr, want.size, want.last, got.addr, got.size, got.last);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: take the budget on each register write, predict on each
    // accepted item, then check any release taken at the same edge.
    // Keeping all three in one process fixes their order within the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_release want;
        t_release got;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                budget_now = cfg_bus.byte_budget;

            if (item_bus.valid && item_bus.ready) begin
                quarantine_step(item_bus.operation, item_bus.block_addr, item_bus.block_size);
                if (row_typed_count < 0) begin
                    foreach (fresh_releases[k])
                        pending_releases.push_back(fresh_releases[k]);
                end else if (row_typed_count == 1) begin
                    pending_releases.push_back(row_typed);
                end
            end

            if (rel_bus.valid && rel_bus.ready) begin
                got.addr = rel_bus.released_addr;
                got.size = rel_bus.released_size;
                got.last = rel_bus.is_last;
                if (pending_releases.size() == 0) begin
                    report_failure("release with nothing owed", '0, got);
                end else begin
                    want = pending_releases.pop_front();
                    if (got.addr !== want.addr || got.size !== want.size ||
                        got.last !== want.last)
                        report_failure("release mismatch", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Release side: random stalls, plus a long hold-off on request so
    // that the block backs up and stalls its item input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req_count != hold_ack_count) begin
            hold_ack_count <= hold_req_count;
            hold_left      <= HOLD_OFF_CYCLES;
            rel_bus.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rel_bus.ready <= 1'b0;
        end else begin
            rel_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // Valid stays high on return so that a back-to-back item needs no toggle.
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] size, input int typed_count,
                             input t_release typed);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.operation  <= op;
        item_bus.block_addr <= addr;
        item_bus.block_size <= size;
        row_typed_count     <= typed_count;
        row_typed           <= typed;
        do
            @(posedge i_clk);
        while (!item_bus.ready);
    endtask

    task automatic send_random_item(input logic [SIZE_W-1:0] budget);
        logic [ADDR_W-1:0] addr;
        addr = {16'($urandom), 32'($urandom)};
        // flushes carry random payload too: the block must ignore it
        if ($urandom_range(99) < 8)
            send_item(OP_FLUSH, addr, $urandom, -1, '0);
        else
            send_item(OP_PUSH, addr, pick_size(budget), -1, '0);
    endtask

    // Drop valid, wait for every owed release, then let a trailing push finish.
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_releases.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the budget register; only ever done with the block idle.
    task automatic write_budget(input logic [SIZE_W-1:0] value);
        drain();
        cfg_bus.valid       <= 1'b1;
        cfg_bus.byte_budget <= value;
        do
            @(posedge i_clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                idle_by_phase  [5];
        int                stall_by_phase [5];
        logic [SIZE_W-1:0] budget_by_phase[5];
        logic [SIZE_W-1:0] phase_budget;

        // hold every input at a known value through reset
        i_rst_n             <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.operation  <= OP_PUSH;
        item_bus.block_addr <= '0;
        item_bus.block_size <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.byte_budget <= '0;

        idle_by_phase   = '{0, 84, 0, 16, 0};
        stall_by_phase  = '{0, 0, 84, 16, 0};
        budget_by_phase = '{32'd4096, 32'hFFFF_FFFF, 32'd640, 32'd0, 32'($urandom)};

        // Directed script, starting from the reset budget.
        // flush of an empty ring: nothing comes back
        add_row(STEP_FLUSH, '0, '0, 0, '0);
        // largest block at the top address: bigger than the budget, back at once
        add_row(STEP_PUSH, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1,
                final_release(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        // zero-size block is held and takes a slot
        add_row(STEP_PUSH, 48'h0, 32'h0, 0, '0);
        // block exactly the size of the budget still fits
        add_row(STEP_PUSH, 48'h1000, BUDGET_RESET, 0, '0);
        // one more byte evicts both held blocks
        add_row(STEP_PUSH, 48'h2000, 32'd1, -1, '0);
        add_row(STEP_FLUSH, '0, '0, 1, final_release(48'h2000, 32'd1));
        // zero budget: any non-empty block is oversized
        add_row(STEP_BUDGET, '0, 32'd0, -1, '0);
        add_row(STEP_PUSH, 48'h3000, 32'd1, 1, final_release(48'h3000, 32'd1));
        // full budget: held bytes plus size must be compared without wrap
        add_row(STEP_BUDGET, '0, 32'hFFFF_FFFF, -1, '0);
        add_row(STEP_PUSH, 48'h5555_5555_5555, 32'hFFFF_FFFF, 0, '0);
        add_row(STEP_PUSH, 48'hAAAA_AAAA_AAAA, 32'd1, 1,
                final_release(48'h5555_5555_5555, 32'hFFFF_FFFF));
        // fill the ring to its entry limit
        for (int i = 1; i < RING_DEPTH; i++)
            add_row(STEP_PUSH, 48'(i) << 32, 32'h100, -1, '0);
        // lower the budget under a full ring: the next push evicts down to it
        add_row(STEP_BUDGET, '0, 32'h300, -1, '0);
        add_row(STEP_PUSH, 48'hC0DE_0000_0000, 32'h0, -1, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STEP_BUDGET)
                write_budget(directed_rows[i].size);
            else
                send_item(directed_rows[i].kind == STEP_FLUSH ? OP_FLUSH : OP_PUSH,
                          directed_rows[i].addr, directed_rows[i].size,
                          directed_rows[i].typed_count, directed_rows[i].typed);
        end

        // Random phases, each with its own budget and idling pattern.
        for (int phase = 0; phase < 5; phase++) begin
            phase_budget = budget_by_phase[phase];
            write_budget(phase_budget);
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            repeat (PHASE_ITEMS) send_random_item(phase_budget);
        end

        // Back-pressure: hold the release side off while items keep coming,
        // then pause the sender until everything owed has come out.
        write_budget(32'd2000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_count <= hold_req_count + 1;
        repeat (PRESSURE_ITEMS) send_random_item(32'd2000);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
